// ===== hw/rtl/vsd_pkg.sv =====
package vsd_pkg;

  localparam int unsigned PRICE_W       = 32;
  localparam int unsigned MAX_ITEMS_DEF = 64;

  // Per-cycle control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic ins;    // a new word is being inserted this cycle
    logic shift;  // the chain moves one place towards the head
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/vsd_cell.sv =====
module vsd_cell
  import vsd_pkg::*;
(
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic [PRICE_W-1:0] price_i,
  input  logic               occ_i,
  input  logic               gt_prev_i,
  input  logic [PRICE_W-1:0] prev_val_i,
  input  logic [PRICE_W-1:0] next_val_i,
  output logic [PRICE_W-1:0] val_o,
  output logic               gt_o
);

  logic [PRICE_W-1:0] value_q, value_d;

  // An empty slot counts as smaller than any word, so the new word lands in
  // the first slot whose holder is strictly smaller or empty.
  assign gt_o  = !occ_i || (price_i > value_q);
  assign val_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift) begin
      value_d = next_val_i;
    end else if (ctrl_i.ins) begin
      if (gt_prev_i) begin
        value_d = prev_val_i;
      end else if (gt_o) begin
        value_d = price_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== hw/rtl/value_sort_descending_unit.sv =====
// The first sorted word is shown in the cycle after the word marked last is
// taken. Throughput: one word per cycle in while loading, then one word
// per cycle out while out_stall_i is low; no new word is taken until the
// whole list has left the block.
// Reset clears the fill count and returns to loading; cell contents are not
// cleared and are only read below the fill count.
module value_sort_descending_unit
  import vsd_pkg::*;
#(
  parameter int unsigned MaxItems = MAX_ITEMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PRICE_W-1:0] price_in_i,
  input  logic               last_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PRICE_W-1:0] price_out_o,
  output logic               last_out_o
);

  localparam int unsigned CntW = $clog2(MaxItems + 1);

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  cell_ctrl_t      ctrl;
  logic            in_acc, out_acc, full;

  logic [PRICE_W-1:0] val  [MaxItems];
  logic               gt   [MaxItems];

  assign full        = (count_q == CntW'(MaxItems));
  assign in_stall_o  = (state_q == ST_EMIT);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign ctrl.ins    = in_acc && !full;
  assign ctrl.shift  = out_acc;
  assign price_out_o = val[0];
  assign last_out_o  = (count_q == CntW'(1));

  for (genvar i = 0; i < MaxItems; i++) begin : g_cell
    logic               gt_prev;
    logic [PRICE_W-1:0] prev_val, next_val;

    if (i == 0) begin : g_head
      assign gt_prev  = 1'b0;
      assign prev_val = '0;
    end else begin : g_body
      assign gt_prev  = gt[i-1];
      assign prev_val = val[i-1];
    end

    if (i == MaxItems - 1) begin : g_tail
      assign next_val = '0;
    end else begin : g_link
      assign next_val = val[i+1];
    end

    vsd_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .price_i    (price_in_i),
      .occ_i      (count_q > CntW'(i)),
      .gt_prev_i  (gt_prev),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .val_o      (val[i]),
      .gt_o       (gt[i])
    );
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    case (state_q)
      ST_LOAD: begin
        if (ctrl.ins) begin
          count_d = count_q + CntW'(1);
        end
        if (in_acc && last_in_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          count_d = count_q - CntW'(1);
          if (last_out_o) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // The list being shown is never empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_q != '0))
    else $error("emitting with an empty chain");

  // Words leave in non-increasing order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_out_o) |=> (price_out_o <= $past(price_out_o)))
    else $error("sorted words out of order");

  // After the final word the block is empty and loading again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_out_o) |=> (count_q == '0 && !out_valid_o))
    else $error("chain not empty after final word");

  // A word offered to a full chain is dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full) |=> (count_q == CntW'(MaxItems)))
    else $error("fill count moved while full");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import vsd_pkg::*;

  localparam int unsigned ListMax    = MAX_ITEMS_DEF;
  localparam int unsigned TotalWords = 430;
  localparam int unsigned CalmWords  = 370;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned ShownLimit = 100;

  // One directed word. Where pinned is set, top is the largest value of the
  // list that this word closes, typed in by hand.
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               last;
    logic               pinned;
    logic [PRICE_W-1:0] top;
  } stim_row_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               last;
  } sorted_word_t;

  stim_row_t directed_rows [0:20] = '{
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0000_0000},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h5555_5555, 1'b1, 1'b0, 32'h0000_0000},
    '{32'h0000_0007, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h0000_0007, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h0000_0007, 1'b1, 1'b1, 32'h0000_0007},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h0000_0001, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h0000_0003, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h0000_0004, 1'b1, 1'b1, 32'h0000_0004},
    '{32'h0000_0004, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h0000_0003, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0004},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h8000_0000}
  };

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [PRICE_W-1:0] price_in  = '0;
  logic               last_in   = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PRICE_W-1:0] price_out;
  logic               last_out;

  // The hand-typed expectation travels with the word it belongs to.
  logic               pin_valid = 1'b0;
  logic [PRICE_W-1:0] pin_top   = '0;

  logic [PRICE_W-1:0] held_prices [$];
  sorted_word_t       sorted_due [$];
  bit                 list_overran  = 1'b0;
  bit                 idle_on       = 1'b0;
  int unsigned        stall_run     = 0;
  int unsigned        stuck_cycles  = 0;
  int unsigned        errors        = 0;
  int unsigned        words_taken   = 0;
  int unsigned        results_seen  = 0;
  int unsigned        lists_done    = 0;
  int unsigned        lists_clipped = 0;

  value_sort_descending_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .price_in_i  (price_in),
    .last_in_i   (last_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .price_out_o (price_out),
    .last_out_o  (last_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (errors < ShownLimit) $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // Stores a taken word while the list has room; on the closing word, ranks the list largest first
  // by pairwise exchange and queues the words that must come out.
  task automatic take_word(input logic [PRICE_W-1:0] p, input logic l,
                           input logic pin, input logic [PRICE_W-1:0] top);
    logic [PRICE_W-1:0] ranked [$];
    logic [PRICE_W-1:0] hold;
    sorted_word_t       w;
    int                 a, b, k;
    words_taken++;
    if (held_prices.size() < ListMax) held_prices.push_back(p);
    else list_overran = 1'b1;
    if (l) begin
      ranked = held_prices;
      for (a = 0; a < ranked.size(); a++) begin
        for (b = a + 1; b < ranked.size(); b++) begin
          if (ranked[a] < ranked[b]) begin
            hold      = ranked[a];
            ranked[a] = ranked[b];
            ranked[b] = hold;
          end
        end
      end
      for (k = 0; k < ranked.size(); k++) begin
        w.price = (k == 0 && pin) ? top : ranked[k];
        w.last  = (k == ranked.size() - 1);
        sorted_due.push_back(w);
      end
      if (list_overran) lists_clipped++;
      lists_done++;
      list_overran = 1'b0;
      held_prices.delete();
    end
  endtask

  task automatic check_word(input logic [PRICE_W-1:0] p, input logic l);
    sorted_word_t w;
    results_seen++;
    if (sorted_due.size() == 0) begin
      flag_error($sformatf("word %h last=%b arrived with nothing expected", p, l));
      return;
    end
    w = sorted_due.pop_front();
    if (p !== w.price)
      flag_error($sformatf("price_out %h, expected %h", p, w.price));
    if (l !== w.last)
      flag_error($sformatf("last_out %b, expected %b (price %h)", l, w.last, w.price));
  endtask

  task automatic send_word(input logic [PRICE_W-1:0] p, input logic l,
                           input logic pin, input logic [PRICE_W-1:0] top);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    price_in  <= p;
    last_in   <= l;
    pin_valid <= pin;
    pin_top   <= top;
    do @(posedge clk); while (in_stall);
  endtask

  // Values sampled here are those from before the edge, so the taken word and
  // the delivered word are seen consistently.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) take_word(price_in, last_in, pin_valid, pin_top);
      if (out_valid && !out_stall) check_word(price_out, last_out);
    end
  end

  always @(posedge clk) begin
    if (stall_run != 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_run = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
    else if (rst_n) stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("Timeout: no word moved for %0d cycles, %0d sorted words still owed",
               stuck_cycles, sorted_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned        len;
    int unsigned        sent;
    logic [PRICE_W-1:0] p;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].price, directed_rows[i].last,
                directed_rows[i].pinned, directed_rows[i].top);

    // Mostly short lists, some long ones, a few that fill the store exactly
    // and a few that overrun it so that the closing word is dropped.
    sent = 0;
    while (sent < TotalWords) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: len = $urandom_range(1, 8);
        12, 13, 14, 15:                       len = $urandom_range(9, 32);
        16, 17:                               len = $urandom_range(33, ListMax - 1);
        18:                                   len = ListMax;
        default:                              len = $urandom_range(ListMax + 1, ListMax + 6);
      endcase
      if (sent >= CalmWords) idle_on = 1'b0;
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: p = $urandom;
          4, 5:       p = $urandom_range(0, 15);
          6:          p = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
          7:          p = 32'hFFFF_FFFF - $urandom_range(0, 3);
          default:    p = $urandom_range(100, 999_999);
        endcase
        send_word(p, k == len - 1, 1'b0, '0);
      end
      sent += len;
    end
    in_valid <= 1'b0;
    idle_on = 1'b0;

    @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sorted %0d lists built from %0d words, %0d of them overrunning the store.",
             lists_done, words_taken, lists_clipped);
    $display("Checked %0d sorted words, %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
